/* rtl/xmad_pkg.sv */
`default_nettype none
package xmad_pkg;

  localparam int unsigned WindowBytes = 15;
  localparam int unsigned NumRegs     = 16;
  localparam int unsigned RegIdxW     = $clog2(NumRegs);

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_READ = 2'd1,
    ACT_EXEC = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OP_STORE_REG = 3'd0,
    OP_STORE_IMM = 3'd1,
    OP_LOAD      = 3'd2,
    OP_LOAD_ZX   = 3'd3,
    OP_TEST      = 3'd4,
    OP_CMP       = 3'd5,
    OP_OR        = 3'd6,
    OP_AND       = 3'd7
  } op_kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  reg_select;
    logic [63:0] reg_data;
    logic [63:0] code_low;
    logic [55:0] code_high;
    logic [63:0] read_data;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  op_kind;
    logic [3:0]  access_bytes;
    logic        wants_read;
    logic        wants_write;
    logic [63:0] store_data;
    logic [3:0]  instr_length;
    logic        flags_update;
    logic        carry_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic [63:0] reg_out;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic decode;
    logic execute;
  } cmd_t;

  // Byte mask for an access size of 1, 2, 4 or 8 bytes.
  function automatic logic [63:0] size_mask(input logic [3:0] sz);
    logic [63:0] m;
    begin
      unique case (sz)
        4'd1:    m = 64'h0000_0000_0000_00FF;
        4'd2:    m = 64'h0000_0000_0000_FFFF;
        4'd4:    m = 64'h0000_0000_FFFF_FFFF;
        default: m = '1;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/xmad_if.sv */
`default_nettype none
interface xmad_req_if;
  logic valid;
  logic ready;
  xmad_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface xmad_rsp_if;
  logic valid;
  logic ready;
  xmad_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/xmad_ctrl.sv */
`default_nettype none
module xmad_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output xmad_pkg::cmd_t     cmd_o
);
  import xmad_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_EXEC   = 4'b0100,
    ST_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Item sequencing: capture, decode, execute, then hold the result.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_OUT;
      ST_OUT:    if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign cmd_o.load_req = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.decode   = (state_q == ST_DECODE);
  assign cmd_o.execute  = (state_q == ST_EXEC);
endmodule
`default_nettype wire

/* rtl/xmad_dp.sv */
`default_nettype none
module xmad_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire xmad_pkg::cmd_t cmd_i,
  input  wire xmad_pkg::req_t req_i,
  output xmad_pkg::rsp_t      rsp_o
);
  import xmad_pkg::*;

  req_t        req_q;
  logic [63:0] regs_q [NumRegs];
  rsp_t        rsp_q, rsp_d;

  // Decode results held between the decode and execute cycles.
  logic        bad_q, bad_d;
  logic [2:0]  kind_q, kind_d;
  logic [3:0]  sz_q, sz_d;
  logic [3:0]  len_q, len_d;
  logic [RegIdxW-1:0] reg_q, reg_d;
  logic [63:0] imm_q, imm_d;

  logic [7:0]  win [16];
  logic        pfx_stop [16];

  always_comb begin
    for (int i = 0; i < 8; i++) win[i] = req_q.code_low[8*i +: 8];
    for (int i = 0; i < 7; i++) win[8+i] = req_q.code_high[8*i +: 8];
    win[15] = 8'h00;
  end

  // Per-byte prefix classification.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pfx_stop[i] = !((win[i] == 8'h66) || (win[i] == 8'hF2) || (win[i] == 8'hF3) ||
                      (win[i][7:4] == 4'h4));
    end
  end

  // Decode: prefix scan, opcode, ModRM/SIB/displacement sizing, immediate.
  always_comb begin
    logic [4:0] p, pos, opl, imm_len, len;
    logic       found, has66, rexw, rexr;
    logic [7:0] op, op2, m, sib;
    logic [63:0] imm;
    p = 5'd0; found = 1'b0; has66 = 1'b0; rexw = 1'b0; rexr = 1'b0;
    bad_d = 1'b0; kind_d = OP_STORE_REG; imm_len = 5'd0; imm = '0;
    for (int i = 0; i < 15; i++) begin
      if (!found) begin
        if (pfx_stop[i]) begin
          found = 1'b1; p = 5'(i);
        end else if (win[i] == 8'h66) begin
          has66 = 1'b1;
        end else if (win[i][7:4] == 4'h4) begin
          rexw = win[i][3]; rexr = win[i][2];
        end
      end
    end
    if (!found) bad_d = 1'b1;
    sz_d = rexw ? 4'd8 : (has66 ? 4'd2 : 4'd4);
    op  = win[p[3:0]];
    op2 = win[4'(p + 5'd1)];
    pos = p + 5'd1;
    unique case (op)
      8'h0F: begin
        kind_d = OP_LOAD_ZX; pos = p + 5'd2;
        if (p + 5'd1 >= 5'(WindowBytes)) bad_d = 1'b1;
        if (op2 == 8'hB6) sz_d = 4'd1;
        else if (op2 == 8'hB7) sz_d = 4'd2;
        else bad_d = 1'b1;
      end
      8'h89: kind_d = OP_STORE_REG;
      8'h88: begin kind_d = OP_STORE_REG; sz_d = 4'd1; end
      8'hC7: begin kind_d = OP_STORE_IMM; imm_len = (has66 && !rexw) ? 5'd2 : 5'd4; end
      8'hC6: begin kind_d = OP_STORE_IMM; sz_d = 4'd1; imm_len = 5'd1; end
      8'h8B: kind_d = OP_LOAD;
      8'h8A: begin kind_d = OP_LOAD; sz_d = 4'd1; end
      8'h85: kind_d = OP_TEST;
      8'h84: begin kind_d = OP_TEST; sz_d = 4'd1; end
      8'h39: kind_d = OP_CMP;
      8'h38: begin kind_d = OP_CMP; sz_d = 4'd1; end
      8'h09: kind_d = OP_OR;
      8'h08: begin kind_d = OP_OR; sz_d = 4'd1; end
      8'h21: kind_d = OP_AND;
      8'h20: begin kind_d = OP_AND; sz_d = 4'd1; end
      default: bad_d = 1'b1;
    endcase
    if (pos >= 5'(WindowBytes)) bad_d = 1'b1;
    m   = win[pos[3:0]];
    sib = win[4'(pos + 5'd1)];
    reg_d = {rexr, m[5:3]};
    opl = 5'd1;
    if (m[7:6] != 2'd3) begin
      if (m[2:0] == 3'd4) begin
        opl = opl + 5'd1;
        if (pos + 5'd1 >= 5'(WindowBytes)) bad_d = 1'b1;
        if (m[7:6] == 2'd0 && sib[2:0] == 3'd5) opl = opl + 5'd4;
      end
      if (m[7:6] == 2'd0 && m[2:0] == 3'd5) opl = opl + 5'd4;
      else if (m[7:6] == 2'd1) opl = opl + 5'd1;
      else if (m[7:6] == 2'd2) opl = opl + 5'd4;
    end
    len = pos + opl + imm_len;
    for (int i = 0; i < 4; i++) begin
      if (5'(i) < imm_len) imm[8*i +: 8] = win[4'(pos + opl + 5'(i))];
    end
    if (imm_len == 5'd4 && sz_d == 4'd8 && imm[31]) imm[63:32] = '1;
    imm_d = imm;
    if (len > 5'(WindowBytes)) bad_d = 1'b1;
    len_d = len[3:0];
  end

  // Execute: operand fetch, arithmetic and flags.
  always_comb begin
    logic [63:0] mask, mem, rv, res, cur;
    logic [64:0] diff;
    logic [5:0]  top;
    rsp_d = '0;
    mask = size_mask(sz_q);
    mem  = req_q.read_data & mask;
    cur  = regs_q[reg_q];
    rv   = cur & mask;
    diff = {1'b0, mem} - {1'b0, rv};
    // Sign bit index is eight times the size minus one.
    top  = {3'(sz_q - 4'd1), 3'b111};
    res  = '0;
    unique case (action_e'(req_q.action))
      ACT_SET:  rsp_d = '0;
      ACT_READ: rsp_d.reg_out = regs_q[req_q.reg_select];
      ACT_NONE: rsp_d.status = 1'b1;
      ACT_EXEC: begin
        if (bad_q) begin
          rsp_d.status = 1'b1;
        end else begin
          rsp_d.op_kind = kind_q;
          rsp_d.access_bytes = sz_q;
          rsp_d.instr_length = len_q;
          unique case (op_kind_e'(kind_q))
            OP_STORE_REG: begin rsp_d.wants_write = 1'b1; rsp_d.store_data = rv; end
            OP_STORE_IMM: begin
              rsp_d.wants_write = 1'b1; rsp_d.store_data = imm_q & mask;
            end
            OP_LOAD, OP_LOAD_ZX: rsp_d.wants_read = 1'b1;
            OP_TEST: begin
              res = mem & rv;
              rsp_d.wants_read = 1'b1; rsp_d.flags_update = 1'b1;
              rsp_d.zero_flag = (res == '0); rsp_d.sign_flag = res[top];
            end
            OP_CMP: begin
              res = diff[63:0] & mask;
              rsp_d.wants_read = 1'b1; rsp_d.flags_update = 1'b1;
              rsp_d.carry_flag = diff[64];
              rsp_d.zero_flag = (res == '0); rsp_d.sign_flag = res[top];
            end
            OP_OR: begin
              rsp_d.wants_read = 1'b1; rsp_d.wants_write = 1'b1;
              rsp_d.store_data = mem | rv;
            end
            OP_AND: begin
              rsp_d.wants_read = 1'b1; rsp_d.wants_write = 1'b1;
              rsp_d.store_data = mem & rv;
            end
            default: rsp_d = '0;
          endcase
        end
      end
      default: rsp_d.status = 1'b1;
    endcase
  end

  // Request, decode and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.decode) begin
      bad_q <= bad_d; kind_q <= kind_d; sz_q <= sz_d;
      len_q <= len_d; reg_q <= reg_d; imm_q <= imm_d;
    end
    if (cmd_i.execute) rsp_q <= rsp_d;
  end

  // Register file: set actions and load merges.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else if (cmd_i.execute) begin
      if (req_q.action == ACT_SET) begin
        regs_q[req_q.reg_select] <= req_q.reg_data;
      end else if (req_q.action == ACT_EXEC && !bad_q) begin
        if (kind_q == OP_LOAD_ZX ||
            (kind_q == OP_LOAD && (sz_q == 4'd4 || sz_q == 4'd8))) begin
          regs_q[reg_q] <= req_q.read_data & size_mask(sz_q);
        end else if (kind_q == OP_LOAD) begin
          regs_q[reg_q] <= (regs_q[reg_q] & ~size_mask(sz_q)) |
                           (req_q.read_data & size_mask(sz_q));
        end
      end
    end
  end

  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

/* rtl/x86_mmio_access_decoder.sv */
`default_nettype none
// After the edge that accepts a transaction, its result is decoded, executed
// into the result register and then offered on the response interface.
// A new transaction is accepted only once the previous result has been taken,
// as the controller steps through the single shared decode datapath.
// Reset (asynchronous, active low) clears the controller and the register file.
module x86_mmio_access_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  xmad_req_if.sink        req_i,
  xmad_rsp_if.source      rsp_o
);
  import xmad_pkg::*;

  cmd_t cmd;

  xmad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .cmd_o      (cmd)
  );

  xmad_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i.payload),
    .rsp_o (rsp_o.payload)
  );
endmodule
`default_nettype wire
